// ===== hdl/csis_pkg.sv =====
// ----------------------------------------------------------------------------
// csis_pkg: shared definitions for the case-insensitive substring search
// Character and field widths, configuration register indexes, case folding.
// ----------------------------------------------------------------------------
package csis_pkg;

    localparam int CHAR_W          = 8;
    localparam int PATTERN_W       = 64;
    localparam int PATTERN_LEN_W   = 4;
    localparam int START_W         = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    localparam char_t CHAR_UPPER_A = 8'h41;
    localparam char_t CHAR_UPPER_Z = 8'h5A;
    localparam char_t CASE_OFFSET  = 8'h20;

    // Fold ASCII A-Z to a-z, pass everything else
    function automatic char_t fold_case(input char_t c);
        char_t r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== hdl/case_insensitive_substring_search.sv =====
// Result: registered in the output register, or in the skid entry on stall.
// Throughput: one text item per cycle while in_ready is high; the window cells
// shift and compare in parallel, and a two-entry result buffer absorbs stalls.
// Reset: rst_n clears the pattern registers, the window, the byte count,
// the match record and the result buffer valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// case_insensitive_substring_search: streaming pattern finder
// Slides text through a chain of window cells and records the first place
// where the configured pattern occurs, ignoring ASCII case.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search
    import csis_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAR_W-1:0]      text_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [START_W-1:0]     match_start,
    output logic                   count_saturated
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (COUNT_BITS > START_W) ? COUNT_BITS : START_W;

    logic [LEN_W-1:0]       pattern_len;
    char_t                  expected   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] compare_en;
    char_t                  window     [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit_ok;

    logic                   accept;
    logic                   active;
    logic                   text_done;
    logic                   at_max;
    logic                   long_enough;
    logic                   hit_now;
    logic [IDX_W-1:0]       start_calc;
    logic                   res_found;
    logic [START_W-1:0]     res_start;
    logic                   res_sat;

    logic [COUNT_BITS-1:0]  byte_count_reg,  byte_count_next;
    logic                   match_seen_reg,  match_seen_next;
    logic [START_W-1:0]     match_index_reg, match_index_next;
    logic                   ended_reg,       ended_next;
    logic                   overflow_reg,    overflow_next;

    logic                   out_valid_reg,   out_valid_next;
    logic                   found_reg,       found_next;
    logic [START_W-1:0]     start_reg,       start_next;
    logic                   sat_reg,         sat_next;
    logic                   skid_valid_reg,  skid_valid_next;
    logic                   skid_found_reg,  skid_found_next;
    logic [START_W-1:0]     skid_start_reg,  skid_start_next;
    logic                   skid_sat_reg,    skid_sat_next;

    assign cfg_ready = 1'b1;

    csis_pattern #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pattern (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pattern_len (pattern_len),
        .expected    (expected),
        .compare_en  (compare_en)
    );

    // Handshake and per-item control
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign active    = accept && !ended_reg && (text_byte != '0);
    assign text_done = accept && last_byte;
    assign at_max    = (byte_count_reg == {COUNT_BITS{1'b1}});

    // Window chain: cell 0 takes the folded text character
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        char_t cell_in;
        if (j == 0)
        begin : g_head
            assign cell_in = fold_case(text_byte);
        end
        else
        begin : g_body
            assign cell_in = window[j-1];
        end
        csis_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (active),
            .clear      (text_done),
            .byte_in    (cell_in),
            .expected   (expected[j]),
            .compare_en (compare_en[j]),
            .byte_out   (window[j]),
            .hit_ok     (hit_ok[j])
        );
    end

    // Detect the first match and its start index
    assign long_enough = ({1'b0, byte_count_reg} + 1'b1) >= (COUNT_BITS + 1)'(pattern_len);
    assign hit_now     = active && !match_seen_reg && (pattern_len != '0)
                         && long_enough && (&hit_ok);
    assign start_calc  = IDX_W'(byte_count_reg) + IDX_W'(1) - IDX_W'(pattern_len);

    // Advance the per-text state, drop it after the last item
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        match_seen_next  = match_seen_reg;
        match_index_next = match_index_reg;
        ended_next       = ended_reg;
        overflow_next    = overflow_reg;
        if (accept && !ended_reg && (text_byte == '0))
        begin
            ended_next = 1'b1;
        end
        if (active)
        begin
            if (at_max)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
        if (hit_now)
        begin
            match_seen_next  = 1'b1;
            match_index_next = start_calc[START_W-1:0];
        end
        if (text_done)
        begin
            byte_count_next  = '0;
            match_seen_next  = 1'b0;
            match_index_next = '0;
            ended_next       = 1'b0;
            overflow_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            match_seen_reg  <= 1'b0;
            match_index_reg <= '0;
            ended_reg       <= 1'b0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            match_seen_reg  <= match_seen_next;
            match_index_reg <= match_index_next;
            ended_reg       <= ended_next;
            overflow_reg    <= overflow_next;
        end
    end

    // Result of the current item, as seen after its update
    assign res_found = match_seen_reg || hit_now;
    assign res_sat   = overflow_reg || (active && at_max);
    always_comb
    begin
        res_start = '0;
        if (match_seen_reg)
        begin
            res_start = match_index_reg;
        end
        else if (hit_now)
        begin
            res_start = start_calc[START_W-1:0];
        end
    end

    // Output register with a skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        sat_next        = sat_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_start_next = skid_start_reg;
        skid_sat_next   = skid_sat_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                found_next      = skid_found_reg;
                start_next      = skid_start_reg;
                sat_next        = skid_sat_reg;
                skid_valid_next = 1'b0;
            end
        end
        if (text_done)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_next = 1'b1;
                skid_found_next = res_found;
                skid_start_next = res_start;
                skid_sat_next   = res_sat;
            end
            else
            begin
                out_valid_next = 1'b1;
                found_next     = res_found;
                start_next     = res_start;
                sat_next       = res_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        found_reg      <= found_next;
        start_reg      <= start_next;
        sat_reg        <= sat_next;
        skid_found_reg <= skid_found_next;
        skid_start_reg <= skid_start_next;
        skid_sat_reg   <= skid_sat_next;
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign match_start     = start_reg;
    assign count_saturated = sat_reg;

endmodule

// ===== hdl/csis_cell.sv =====
// ----------------------------------------------------------------------------
// csis_cell: one window position of the search chain
// Holds one folded text character, passes it on to the next cell as the
// window shifts, and compares the incoming character with its pattern slot.
// ----------------------------------------------------------------------------
module csis_cell
    import csis_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  logic  clear,
    input  char_t byte_in,
    input  char_t expected,
    input  logic  compare_en,
    output char_t byte_out,
    output logic  hit_ok
);

    char_t byte_reg;
    char_t byte_next;

    // Shift in from the left neighbor, drop the window at end of text
    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Compare the character this cell is about to hold
    assign hit_ok   = !compare_en || (byte_in == expected);
    assign byte_out = byte_reg;

endmodule

// ===== hdl/csis_pattern.sv =====
// ----------------------------------------------------------------------------
// csis_pattern: pattern registers and per-cell compare setup
// Takes configuration writes, works out the effective pattern length and
// hands each window cell its folded expected character and enable.
// ----------------------------------------------------------------------------
module csis_pattern
    import csis_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0]   cfg_data,
    output logic [LEN_W-1:0]       pattern_len,
    output char_t                  expected [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0] compare_en
);

    logic [PATTERN_W-1:0]     pattern_bytes_reg;
    logic [PATTERN_W-1:0]     pattern_bytes_next;
    logic [PATTERN_LEN_W-1:0] pattern_length_reg;
    logic [PATTERN_LEN_W-1:0] pattern_length_next;

    // Take register writes
    always_comb
    begin
        pattern_bytes_next  = pattern_bytes_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_BYTES:  pattern_bytes_next  = cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_next = cfg_data[PATTERN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else
        begin
            pattern_bytes_reg  <= pattern_bytes_next;
            pattern_length_reg <= pattern_length_next;
        end
    end

    // Clamp the length, then cut the pattern at its first zero character
    always_comb
    begin
        logic [LEN_W-1:0] lim;
        if (pattern_length_reg > PATTERN_LEN_W'(MAX_PATTERN))
        begin
            lim = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            lim = LEN_W'(pattern_length_reg);
        end
        pattern_len = lim;
        for (int i = MAX_PATTERN - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < lim && pattern_bytes_reg[CHAR_W*i +: CHAR_W] == '0)
            begin
                pattern_len = LEN_W'(i);
            end
        end
    end

    // Cell j holds the character j positions back; it must equal
    // pattern character len-1-j
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            expected[j]   = '0;
            compare_en[j] = (LEN_W'(j) < pattern_len);
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                if ((k + j + 1) == int'(pattern_len))
                begin
                    expected[j] = fold_case(pattern_bytes_reg[CHAR_W*k +: CHAR_W]);
                end
            end
        end
    end

endmodule
